>>> src/byte_ring_fifo_peek_skip_unit_defines.svh
// assertion helpers used by brfps_ctrl
`ifndef BYTE_RING_FIFO_PEEK_SKIP_UNIT_DEFINES_SVH
`define BYTE_RING_FIFO_PEEK_SKIP_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BRFPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BRFPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/brfps_pkg.sv
`default_nettype none
package brfps_pkg;

  localparam int DEPTH_LOG2 = 10;
  localparam int MAX_BURST  = 64;

  localparam int DEPTH   = 1 << DEPTH_LOG2;
  localparam int IDX_W   = DEPTH_LOG2;
  localparam int PTR_W   = DEPTH_LOG2 + 1;
  localparam int TYPE_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 11;
  localparam int STAT_W  = 2;
  // wide enough for the depth and for any requested length
  localparam int CNT_W   = (PTR_W > LEN_W) ? PTR_W : LEN_W;
  localparam int BURST_W = $clog2(MAX_BURST + 1);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  localparam logic [TYPE_W-1:0] REQ_WRITE   = TYPE_W'(0);
  localparam logic [TYPE_W-1:0] REQ_READ    = TYPE_W'(1);
  localparam logic [TYPE_W-1:0] REQ_PEEK    = TYPE_W'(2);
  localparam logic [TYPE_W-1:0] REQ_DISCARD = TYPE_W'(3);
  localparam logic [TYPE_W-1:0] REQ_RESET   = TYPE_W'(4);

  localparam logic [STAT_W-1:0] STAT_OK     = STAT_W'(0);
  localparam logic [STAT_W-1:0] STAT_REJECT = STAT_W'(1);
  localparam logic [STAT_W-1:0] STAT_EMPTY  = STAT_W'(2);
  localparam logic [STAT_W-1:0] STAT_ZERO   = STAT_W'(3);

  typedef struct packed {
    logic               accept;
    logic               issue;
    logic [BURST_W-1:0] idx;
    logic               move;
    logic               move_last;
  } brfps_cmd_t;

  typedef struct packed {
    logic               stream_start;
    logic [BURST_W-1:0] stream_len;
  } brfps_sts_t;

endpackage
`default_nettype wire

>>> src/brfps_if.sv
`default_nettype none
interface brfps_req_if;
  import brfps_pkg::*;

  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [BYTE_W-1:0] wr_byte;
  logic              wr_first;
  logic              wr_last;
  logic [LEN_W-1:0]  req_len;

  modport source (output valid, req_type, wr_byte, wr_first, wr_last, req_len,
                  input ready);
  modport sink (input valid, req_type, wr_byte, wr_first, wr_last, req_len,
                output ready);
endinterface

interface brfps_rsp_if;
  import brfps_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rd_byte;
  logic              rd_valid;
  logic              last;
  logic [STAT_W-1:0] status;
  logic [LEN_W-1:0]  done_count;
  logic [LEN_W-1:0]  used_count;
  logic [LEN_W-1:0]  free_count;
  logic              is_empty;
  logic              is_full;

  modport source (output valid, rd_byte, rd_valid, last, status, done_count,
                  used_count, free_count, is_empty, is_full,
                  input ready);
  modport sink (input valid, rd_byte, rd_valid, last, status, done_count,
                used_count, free_count, is_empty, is_full,
                output ready);
endinterface
`default_nettype wire

>>> src/brfps_ctrl.sv
`default_nettype none
`include "byte_ring_fifo_peek_skip_unit_defines.svh"
module brfps_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_ready,
  output logic                       rsp_valid,
  input  wire logic                  rsp_ready,
  input  wire brfps_pkg::brfps_sts_t sts,
  output brfps_pkg::brfps_cmd_t      cmd
);
  import brfps_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_STREAM = 1'b1;

  logic               state, state_next;
  logic [BURST_W-1:0] cnt, cnt_next, cnt_inc;
  logic [BURST_W-1:0] n_len, n_len_next;
  logic               pend, pend_next;
  logic               pend_last, pend_last_next;
  logic               out_valid, out_valid_next;
  logic               accept, issue, move;

  assign req_ready = (state == ST_IDLE) && (!out_valid || rsp_ready);
  assign accept    = req_valid && req_ready;
  // read data register hands its byte to the output register
  assign move      = pend && (!out_valid || rsp_ready);
  assign issue     = (state == ST_STREAM) && (cnt != n_len) && (!pend || move);
  assign cnt_inc   = cnt + BURST_W'(1);
  assign rsp_valid = out_valid;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    n_len_next     = n_len;
    pend_next      = pend;
    pend_last_next = pend_last;
    out_valid_next = out_valid;
    if (accept && sts.stream_start) begin
      state_next = ST_STREAM;
      cnt_next   = '0;
      n_len_next = sts.stream_len;
    end
    if (issue) begin
      cnt_next       = cnt_inc;
      pend_next      = 1'b1;
      pend_last_next = (cnt_inc == n_len);
    end else if (move) begin
      pend_next = 1'b0;
    end
    if (move && pend_last) begin
      state_next = ST_IDLE;
    end
    if ((accept && !sts.stream_start) || move) begin
      out_valid_next = 1'b1;
    end else if (rsp_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      n_len     <= '0;
      pend      <= 1'b0;
      pend_last <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      n_len     <= n_len_next;
      pend      <= pend_next;
      pend_last <= pend_last_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    cmd.accept    = accept;
    cmd.issue     = issue;
    cmd.idx       = cnt;
    cmd.move      = move;
    cmd.move_last = pend_last;
  end

  `BRFPS_ASSERT_IMP(a_ready_idle, req_ready, !pend && state == ST_IDLE, "request taken during stream")
  `BRFPS_ASSERT_IMP(a_final_held, state == ST_STREAM && cnt == n_len, pend, "stream lost its final byte")
  `BRFPS_ASSERT_NXT(a_stream_open, accept && sts.stream_start, state == ST_STREAM && cnt == '0 && !pend, "stream did not open cleanly")
  `BRFPS_ASSERT_NXT(a_move_shown, move, out_valid, "moved byte not presented")

endmodule
`default_nettype wire

>>> src/brfps_dp.sv
`default_nettype none
module brfps_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire brfps_pkg::brfps_cmd_t        cmd,
  output brfps_pkg::brfps_sts_t             sts,
  input  wire logic [brfps_pkg::TYPE_W-1:0] req_type,
  input  wire logic [brfps_pkg::BYTE_W-1:0] wr_byte,
  input  wire logic                         wr_first,
  input  wire logic                         wr_last,
  input  wire logic [brfps_pkg::LEN_W-1:0]  req_len,
  output logic [brfps_pkg::BYTE_W-1:0]      rd_byte,
  output logic                              rd_valid,
  output logic                              last,
  output logic [brfps_pkg::STAT_W-1:0]      status,
  output logic [brfps_pkg::LEN_W-1:0]       done_count,
  output logic [brfps_pkg::LEN_W-1:0]       used_count,
  output logic [brfps_pkg::LEN_W-1:0]       free_count,
  output logic                              is_empty,
  output logic                              is_full
);
  import brfps_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata;

  logic [PTR_W-1:0] rp, wp, rp_next, wp_next, base, base_next;
  logic [PTR_W-1:0] diff_cur, diff_new;
  logic             b_act, b_act_next, b_rej, b_rej_next;
  logic [LEN_W-1:0] b_off, b_off_next, b_lim, b_lim_next;
  logic [CNT_W-1:0] used_cur, free_cur, len_c, n_all, used_new;
  logic [IDX_W-1:0] waddr, raddr;
  logic             wr_en, res_last;
  logic [STAT_W-1:0] res_status;
  logic [LEN_W-1:0]  res_done;
  logic [BURST_W-1:0] n_burst;

  assign diff_cur = wp - rp;
  assign used_cur = CNT_W'(diff_cur);
  assign free_cur = DEPTH_C - used_cur;
  assign len_c    = CNT_W'(req_len);
  assign raddr    = base[IDX_W-1:0] + IDX_W'(cmd.idx);

  always_comb begin
    rp_next          = rp;
    wp_next          = wp;
    base_next        = base;
    b_act_next       = b_act;
    b_rej_next       = b_rej;
    b_off_next       = b_off;
    b_lim_next       = b_lim;
    wr_en            = 1'b0;
    waddr            = wp[IDX_W-1:0];
    res_last         = 1'b1;
    res_status       = STAT_OK;
    res_done         = '0;
    n_all            = '0;
    n_burst          = '0;
    sts.stream_start = 1'b0;
    sts.stream_len   = '0;
    case (req_type)
      REQ_WRITE: begin
        if (wr_first) begin
          b_act_next = 1'b1;
          b_off_next = '0;
          b_lim_next = req_len;
          b_rej_next = (req_len == '0) || (len_c > free_cur);
        end
        if (!b_act_next) begin
          res_status = STAT_REJECT;
        end else if (b_rej_next) begin
          res_status = (b_lim_next == '0) ? STAT_ZERO : STAT_REJECT;
        end else begin
          if (b_off_next < b_lim_next) begin
            wr_en      = 1'b1;
            waddr      = wp[IDX_W-1:0] + IDX_W'(b_off_next);
            b_off_next = b_off_next + LEN_W'(1);
          end
          res_done = b_off_next;
        end
        res_last = wr_last;
        // last byte commits the burst, or drops a rejected one
        if (wr_last && b_act_next) begin
          if (!b_rej_next) begin
            wp_next = wp + PTR_W'(b_off_next);
          end
          b_act_next = 1'b0;
          b_rej_next = 1'b0;
          b_off_next = '0;
        end
      end
      REQ_READ, REQ_PEEK, REQ_DISCARD: begin
        if (req_len == '0) begin
          res_status = STAT_ZERO;
        end else if (used_cur == '0) begin
          res_status = STAT_EMPTY;
        end else begin
          n_all = (len_c < used_cur) ? len_c : used_cur;
          if (req_type == REQ_DISCARD) begin
            rp_next  = rp + PTR_W'(n_all);
            res_done = LEN_W'(n_all);
          end else begin
            n_burst = (n_all > CNT_W'(MAX_BURST)) ? BURST_W'(MAX_BURST)
                                                   : BURST_W'(n_all);
            sts.stream_start = 1'b1;
            sts.stream_len   = n_burst;
            base_next        = rp;
            if (req_type == REQ_READ) begin
              rp_next = rp + PTR_W'(n_burst);
            end
            res_done = LEN_W'(n_burst);
          end
        end
      end
      REQ_RESET: begin
        rp_next    = '0;
        wp_next    = '0;
        b_act_next = 1'b0;
        b_rej_next = 1'b0;
        b_off_next = '0;
        b_lim_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign diff_new = wp_next - rp_next;
  assign used_new = CNT_W'(diff_new);

  always_ff @(posedge clk) begin
    if (rst) begin
      rp    <= '0;
      wp    <= '0;
      base  <= '0;
      b_act <= 1'b0;
      b_rej <= 1'b0;
      b_off <= '0;
      b_lim <= '0;
    end else if (cmd.accept) begin
      rp    <= rp_next;
      wp    <= wp_next;
      base  <= base_next;
      b_act <= b_act_next;
      b_rej <= b_rej_next;
      b_off <= b_off_next;
      b_lim <= b_lim_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem[waddr] <= wr_byte;
    end
    if (cmd.issue) begin
      rdata <= mem[raddr];
    end
  end

  // result register: counts load with the request, bytes load as they stream
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_byte    <= '0;
      rd_valid   <= 1'b0;
      last       <= res_last;
      status     <= res_status;
      done_count <= res_done;
      used_count <= LEN_W'(used_new);
      free_count <= LEN_W'(DEPTH_C - used_new);
      is_empty   <= (used_new == '0);
      is_full    <= (used_new == DEPTH_C);
    end else if (cmd.move) begin
      rd_byte  <= rdata;
      rd_valid <= 1'b1;
      last     <= cmd.move_last;
    end
  end

endmodule
`default_nettype wire

>>> src/byte_ring_fifo_peek_skip_unit.sv
`default_nettype none
// Byte ring FIFO of 2**DEPTH_LOG2 bytes with all-or-nothing write bursts,
// consuming read, non-consuming peek, discard and a soft reset request.
// A write byte, discard, reset, zero-length, empty or unused-type request
// gives one response; the next request is taken as soon as the response
// register is free, so a stream of write bytes runs at one per cycle when
// the sink keeps up. Read and peek return min(req_len, used, MAX_BURST)
// bytes, one response per byte at one per cycle when the sink keeps up,
// each through the read data register and then the response register;
// no request is taken until the last byte reaches the response register. The
// byte store has one write port and one registered read port, and that read
// port sets the streaming pace. Stored bytes are not cleared by reset; only
// committed bytes are ever read. Every response carries the used and free
// counts and the empty and full flags after the request.
module byte_ring_fifo_peek_skip_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  brfps_req_if.sink  req,
  brfps_rsp_if.source rsp
);
  import brfps_pkg::*;

  brfps_cmd_t cmd;
  brfps_sts_t sts;

  brfps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  brfps_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (req.req_type),
    .wr_byte    (req.wr_byte),
    .wr_first   (req.wr_first),
    .wr_last    (req.wr_last),
    .req_len    (req.req_len),
    .rd_byte    (rsp.rd_byte),
    .rd_valid   (rsp.rd_valid),
    .last       (rsp.last),
    .status     (rsp.status),
    .done_count (rsp.done_count),
    .used_count (rsp.used_count),
    .free_count (rsp.free_count),
    .is_empty   (rsp.is_empty),
    .is_full    (rsp.is_full)
  );

endmodule
`default_nettype wire

>>> tb/sv/tb_byte_ring_fifo_peek_skip_unit.sv
`timescale 1ns / 100ps
module tb_byte_ring_fifo_peek_skip_unit;
  import brfps_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_UNUSED_LO = TYPE_W'(5);
  localparam logic [TYPE_W-1:0] REQ_UNUSED_HI = '1;
  localparam int IDLE_MAX     = 12;
  localparam int RAND_ITEMS   = 50;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [TYPE_W-1:0] req_type;
    logic [BYTE_W-1:0] wr_byte;
    logic              wr_first;
    logic              wr_last;
    logic [LEN_W-1:0]  req_len;
  } fifo_req_t;

  typedef struct {
    logic [BYTE_W-1:0] rd_byte;
    logic              rd_valid;
    logic              last;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  done_count;
    logic [LEN_W-1:0]  used_count;
    logic [LEN_W-1:0]  free_count;
    logic              is_empty;
    logic              is_full;
  } fifo_rsp_t;

  logic clk = 1'b0;
  logic rst;

  brfps_req_if req_ch ();
  brfps_rsp_if rsp_ch ();

  byte_ring_fifo_peek_skip_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted fifo contents and pointers
  logic [BYTE_W-1:0] fifo_mem [DEPTH];
  logic [PTR_W-1:0]  rd_ptr = '0;
  logic [PTR_W-1:0]  wr_ptr = '0;
  logic              in_burst = 1'b0;
  logic              burst_bad = 1'b0;
  int                burst_cnt = 0;
  int                burst_len = 0;

  fifo_rsp_t exp_rsp_q [$];
  int        mismatches = 0;
  int        sent_items = 0;
  int        quiet_cycles = 0;
  int        hold_left = 0;
  int        stall_left = 0;
  bit        idle_on = 1'b1;

  function automatic int idle_draw();
    return idle_on ? $urandom_range(0, IDLE_MAX) : 0;
  endfunction

  function automatic int held_bytes();
    logic [PTR_W-1:0] diff;
    diff = wr_ptr - rd_ptr;
    return int'(diff);
  endfunction

  function automatic void log_expect(input logic [BYTE_W-1:0] data, input logic dv,
                                     input logic fin, input logic [STAT_W-1:0] st,
                                     input int done);
    fifo_rsp_t e;
    int used;
    used = held_bytes();
    e.rd_byte    = data;
    e.rd_valid   = dv;
    e.last       = fin;
    e.status     = st;
    e.done_count = LEN_W'(done);
    e.used_count = LEN_W'(used);
    e.free_count = LEN_W'(DEPTH - used);
    e.is_empty   = (used == 0);
    e.is_full    = (used == DEPTH);
    exp_rsp_q.push_back(e);
  endfunction

  function automatic void predict_fifo(input fifo_req_t r);
    logic [STAT_W-1:0] st;
    logic [PTR_W-1:0]  start;
    int held;
    int n;
    int done;
    held = held_bytes();
    case (r.req_type)
      REQ_WRITE: begin
        st = STAT_OK;
        done = 0;
        if (r.wr_first) begin
          in_burst  = 1'b1;
          burst_cnt = 0;
          burst_len = int'(r.req_len);
          burst_bad = (r.req_len == 0) || (int'(r.req_len) > DEPTH - held);
        end
        if (!in_burst) begin
          st = STAT_REJECT;
        end else if (burst_bad) begin
          st = (burst_len == 0) ? STAT_ZERO : STAT_REJECT;
        end else begin
          // bytes past the announced length are dropped
          if (burst_cnt < burst_len) begin
            fifo_mem[IDX_W'(wr_ptr + PTR_W'(burst_cnt))] = r.wr_byte;
            burst_cnt++;
          end
          done = burst_cnt;
        end
        if (r.wr_last && in_burst) begin
          if (!burst_bad) wr_ptr = wr_ptr + PTR_W'(burst_cnt);
          in_burst  = 1'b0;
          burst_bad = 1'b0;
          burst_cnt = 0;
        end
        log_expect('0, 1'b0, r.wr_last, st, done);
      end
      REQ_READ, REQ_PEEK, REQ_DISCARD: begin
        if (r.req_len == 0) begin
          log_expect('0, 1'b0, 1'b1, STAT_ZERO, 0);
        end else if (held == 0) begin
          log_expect('0, 1'b0, 1'b1, STAT_EMPTY, 0);
        end else begin
          n = (int'(r.req_len) < held) ? int'(r.req_len) : held;
          if (r.req_type == REQ_DISCARD) begin
            // discard is not capped at the burst size
            rd_ptr = rd_ptr + PTR_W'(n);
            log_expect('0, 1'b0, 1'b1, STAT_OK, n);
          end else begin
            if (n > MAX_BURST) n = MAX_BURST;
            start = rd_ptr;
            if (r.req_type == REQ_READ) rd_ptr = rd_ptr + PTR_W'(n);
            for (int i = 0; i < n; i++) begin
              log_expect(fifo_mem[IDX_W'(start + PTR_W'(i))], 1'b1, i == n - 1, STAT_OK, n);
            end
          end
        end
      end
      REQ_RESET: begin
        rd_ptr    = '0;
        wr_ptr    = '0;
        in_burst  = 1'b0;
        burst_bad = 1'b0;
        burst_cnt = 0;
        burst_len = 0;
        log_expect('0, 1'b0, 1'b1, STAT_OK, 0);
      end
      default: begin
        log_expect('0, 1'b0, 1'b1, STAT_OK, 0);
      end
    endcase
  endfunction

  function automatic fifo_req_t mk_req(input logic [TYPE_W-1:0] kind,
                                       input logic [BYTE_W-1:0] data, input logic first,
                                       input logic fin, input logic [LEN_W-1:0] len);
    fifo_req_t r;
    r.req_type = kind;
    r.wr_byte  = data;
    r.wr_first = first;
    r.wr_last  = fin;
    r.req_len  = len;
    return r;
  endfunction

  // non-write request: the write fields are don't-care, so scramble them
  function automatic fifo_req_t mk_ask(input logic [TYPE_W-1:0] kind,
                                       input logic [LEN_W-1:0] len);
    return mk_req(kind, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), len);
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return LEN_W'($urandom_range(MAX_BURST + 1, DEPTH));
    return LEN_W'($urandom_range(1, 48));
  endfunction

  task automatic send_req(input fifo_req_t r);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= r.req_type;
    req_ch.wr_byte  <= r.wr_byte;
    req_ch.wr_first <= r.wr_first;
    req_ch.wr_last  <= r.wr_last;
    req_ch.req_len  <= r.req_len;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    predict_fifo(r);
    sent_items++;
  endtask

  // last_at < 0 leaves the burst open
  task automatic send_burst(input int announced, input int nbytes, input int last_at);
    for (int k = 0; k < nbytes; k++) begin
      send_req(mk_req(REQ_WRITE, BYTE_W'($urandom_range(0, 255)), k == 0, k == last_at,
                      (k == 0) ? LEN_W'(announced) : LEN_W'($urandom_range(0, DEPTH))));
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (exp_rsp_q.size() != 0);
  endtask

  task automatic test_empty_requests();
    send_req(mk_ask(REQ_READ, 1));
    send_req(mk_ask(REQ_PEEK, DEPTH));
    send_req(mk_ask(REQ_DISCARD, 5));
    send_req(mk_ask(REQ_READ, 0));
    send_req(mk_ask(REQ_PEEK, 0));
    send_req(mk_ask(REQ_DISCARD, 0));
    // write byte with no burst open
    send_req(mk_req(REQ_WRITE, 8'h5A, 1'b0, 1'b1, 7));
    for (int c = REQ_UNUSED_LO; c <= REQ_UNUSED_HI; c++) begin
      send_req(mk_ask(TYPE_W'(c), LEN_W'($urandom_range(0, DEPTH))));
    end
  endtask

  task automatic test_write_bursts();
    send_burst(0, 2, 1);
    send_req(mk_req(REQ_WRITE, 8'h00, 1'b1, 1'b0, 3));
    send_req(mk_req(REQ_WRITE, 8'hFF, 1'b0, 1'b0, DEPTH));
    send_req(mk_req(REQ_WRITE, 8'hA5, 1'b0, 1'b1, 0));
    send_req(mk_ask(REQ_PEEK, DEPTH));
    send_burst(4, 2, 1);
    send_burst(2, 3, 2);
    // open burst abandoned by the next first byte
    send_burst(5, 1, -1);
    send_burst(2, 2, 1);
    send_burst(DEPTH, 2, 1);
    send_req(mk_ask(REQ_READ, 2));
    send_req(mk_ask(REQ_DISCARD, 1));
    send_req(mk_ask(REQ_READ, DEPTH));
    send_burst(3, 1, -1);
    send_req(mk_ask(REQ_RESET, LEN_W'($urandom_range(0, DEPTH))));
    send_req(mk_ask(REQ_READ, 1));
  endtask

  task automatic test_long_burst();
    send_req(mk_ask(REQ_RESET, 0));
    send_burst(MAX_BURST + 2, MAX_BURST + 2, MAX_BURST + 1);
    // peek is capped at the burst size, discard is not
    send_req(mk_ask(REQ_PEEK, MAX_BURST + 1));
    send_req(mk_ask(REQ_READ, 1));
    send_req(mk_ask(REQ_DISCARD, DEPTH));
    send_req(mk_ask(REQ_PEEK, 1));
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_left = HOLD_CYCLES;
    send_burst(24, 24, 23);
    send_req(mk_ask(REQ_READ, 16));
    send_req(mk_ask(REQ_PEEK, MAX_BURST));
    send_req(mk_ask(REQ_DISCARD, 3));
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic send_broken_burst();
    int len;
    int nb;
    case ($urandom_range(0, 5))
      0: begin
        len = $urandom_range(2, 12);
        nb = $urandom_range(1, len - 1);
        send_burst(len, nb, nb - 1);
      end
      1: begin
        len = $urandom_range(1, 8);
        nb = len + $urandom_range(1, 4);
        send_burst(len, nb, nb - 1);
      end
      2: begin
        nb = $urandom_range(1, 3);
        send_burst(0, nb, nb - 1);
      end
      3: begin
        nb = $urandom_range(1, 6);
        send_burst(nb + 3, nb, -1);
      end
      4: begin
        send_req(mk_req(REQ_WRITE, BYTE_W'($urandom_range(0, 255)), 1'b0,
                        1'($urandom_range(0, 1)), LEN_W'($urandom_range(0, DEPTH))));
      end
      default: begin
        // announce more than the free room, capped at DEPTH
        len = DEPTH - held_bytes() + $urandom_range(1, 8);
        if (len > DEPTH) len = DEPTH;
        send_burst(len, 2, 1);
      end
    endcase
  endtask

  task automatic test_random_traffic();
    int pick;
    int len;
    int seq;
    int start_cnt;
    start_cnt = sent_items;
    seq = 0;
    while (sent_items - start_cnt < RAND_ITEMS) begin
      seq++;
      // alternate stretches with and without idling
      if (seq % 8 == 0) idle_on = !idle_on;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        len = $urandom_range(1, 16);
        send_burst(len, len, len - 1);
      end else if (pick < 58) begin
        send_req(mk_ask(REQ_READ, pick_len()));
      end else if (pick < 68) begin
        send_req(mk_ask(REQ_PEEK, pick_len()));
      end else if (pick < 75) begin
        send_req(mk_ask(REQ_DISCARD, pick_len()));
      end else if (pick < 90) begin
        send_broken_burst();
      end else if (pick < 93) begin
        send_req(mk_ask(REQ_RESET, LEN_W'($urandom_range(0, DEPTH))));
      end else if (pick < 96) begin
        send_req(mk_ask(TYPE_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)),
                        LEN_W'($urandom_range(0, DEPTH))));
      end else begin
        wait_drained();
      end
    end
    idle_on = 1'b1;
  endtask

  // response side ready, with per-transfer stalls and the long hold-off
  always @(posedge clk) begin : rsp_ready_drive
    int gap;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      gap = (rsp_ch.valid && rsp_ch.ready) ? idle_draw() : 0;
      rsp_ch.ready <= (gap == 0);
      stall_left = (gap > 0) ? gap - 1 : 0;
    end
  end

  task automatic check_field(input string fname, input logic [LEN_W-1:0] want,
                             input logic [LEN_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    fifo_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (exp_rsp_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending, expected none, actual status %0d used %0d",
                 $time, rsp_ch.status, rsp_ch.used_count);
      end else begin
        want = exp_rsp_q.pop_front();
        check_field("rd_byte", LEN_W'(want.rd_byte), LEN_W'(rsp_ch.rd_byte));
        check_field("rd_valid", LEN_W'(want.rd_valid), LEN_W'(rsp_ch.rd_valid));
        check_field("last", LEN_W'(want.last), LEN_W'(rsp_ch.last));
        check_field("status", LEN_W'(want.status), LEN_W'(rsp_ch.status));
        check_field("done_count", want.done_count, rsp_ch.done_count);
        check_field("used_count", want.used_count, rsp_ch.used_count);
        check_field("free_count", want.free_count, rsp_ch.free_count);
        check_field("is_empty", LEN_W'(want.is_empty), LEN_W'(rsp_ch.is_empty));
        check_field("is_full", LEN_W'(want.is_full), LEN_W'(rsp_ch.is_full));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results pending",
               $time, QUIET_LIMIT, exp_rsp_q.size());
      $display("[byte_ring_fifo_peek_skip_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_WRITE;
    req_ch.wr_byte  = '0;
    req_ch.wr_first = 1'b0;
    req_ch.wr_last  = 1'b0;
    req_ch.req_len  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_empty_requests();
    test_write_bursts();
    test_long_burst();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && exp_rsp_q.size() == 0) begin
      $display("[byte_ring_fifo_peek_skip_unit] OK");
    end else begin
      $display("[byte_ring_fifo_peek_skip_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> byte_ring_fifo_peek_skip_unit.f
+incdir+src
src/brfps_pkg.sv
src/brfps_if.sv
src/brfps_ctrl.sv
src/brfps_dp.sv
src/byte_ring_fifo_peek_skip_unit.sv
tb/sv/tb_byte_ring_fifo_peek_skip_unit.sv
